### rtl/kas_pkg.sv
// Shared types and constants for the key argsort engine.
`timescale 1ns / 1ps

package kas_pkg;

  localparam int CAPACITY   = 64;
  // Stored key width; keys are sign-extended from bit KEY_BITS-1.
  localparam int KEY_BITS   = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IN_KEY_W   = 32;
  localparam int OUT_IDX_W  = 6;

  typedef struct packed {
    logic signed [IN_KEY_W-1:0] key;
    logic                       last;
  } load_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]       sorted_index;
    logic signed [IN_KEY_W-1:0] sorted_key;
    logic                       run_end;
    logic                       dropped;
  } result_t;

  // One store entry: key with its load position.
  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [IDX_W-1:0]           pos;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_ctl_t;

  typedef struct packed {
    logic load;
    logic valid;
    logic run_end;
    logic dropped;
  } emit_t;

endpackage

### rtl/kas_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/kas_seq.sv
// Sequencer: insertion walk with the shared key comparator, and run emission.
`timescale 1ns / 1ps

module kas_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  output logic              load_ready,
  input  kas_pkg::load_t    load,
  input  logic              result_ready,
  input  kas_pkg::entry_t   rdata,
  output kas_pkg::ram_ctl_t ram,
  output kas_pkg::emit_t    emit
);

  import kas_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_FETCH    = 7'b0000010,
    ST_CMP      = 7'b0000100,
    ST_PLACE    = 7'b0001000,
    ST_EMIT_RD  = 7'b0010000,
    ST_EMIT_LD  = 7'b0100000,
    ST_EMIT_OUT = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] ecnt, ecnt_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic             overflow_seen, overflow_seen_next;
  entry_t           hold, hold_next;
  logic             last_hold, last_hold_next;
  logic             greater;
  logic             final_rank;

  // Shared comparator: stored key strictly above the incoming one moves up.
  assign greater    = rdata.key > hold.key;
  assign final_rank = CNT_W'(ecnt) == fill_count - 1'b1;

  always_comb begin
    state_next         = state;
    idx_next           = idx;
    ecnt_next          = ecnt;
    fill_count_next    = fill_count;
    overflow_seen_next = overflow_seen;
    hold_next          = hold;
    last_hold_next     = last_hold;
    load_ready         = 1'b0;
    ram.we             = 1'b0;
    ram.waddr          = idx;
    ram.wdata          = hold;
    ram.raddr          = idx - 1'b1;
    emit.load          = 1'b0;
    emit.valid         = 1'b0;
    emit.run_end       = final_rank;
    emit.dropped       = overflow_seen;

    case (state)
      ST_IDLE: begin
        load_ready = 1'b1;
        if (load_valid) begin
          hold_next.key  = load.key[KEY_BITS-1:0];
          hold_next.pos  = fill_count[IDX_W-1:0];
          last_hold_next = load.last;
          if (fill_count < CNT_W'(CAPACITY)) begin
            if (fill_count == '0) begin
              // Empty store: place straight away.
              ram.we          = 1'b1;
              ram.waddr       = '0;
              ram.wdata.key   = load.key[KEY_BITS-1:0];
              ram.wdata.pos   = '0;
              fill_count_next = fill_count + 1'b1;
              state_next      = load.last ? ST_EMIT_RD : ST_IDLE;
            end else begin
              idx_next   = fill_count[IDX_W-1:0];
              state_next = ST_FETCH;
            end
          end else begin
            // Drop the beat, keep the held set.
            overflow_seen_next = 1'b1;
            state_next         = load.last ? ST_EMIT_RD : ST_IDLE;
          end
        end
      end
      ST_FETCH: begin
        ram.raddr  = idx - 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        ram.we = 1'b1;
        if (greater) begin
          ram.wdata = rdata;
          idx_next  = idx - 1'b1;
          if (idx == IDX_W'(1)) begin
            state_next = ST_PLACE;
          end else begin
            ram.raddr  = idx - IDX_W'(2);
            state_next = ST_CMP;
          end
        end else begin
          ram.wdata       = hold;
          fill_count_next = fill_count + 1'b1;
          state_next      = last_hold ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_PLACE: begin
        ram.we          = 1'b1;
        ram.wdata       = hold;
        fill_count_next = fill_count + 1'b1;
        state_next      = last_hold ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        ram.raddr  = ecnt;
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        emit.load  = 1'b1;
        state_next = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        emit.valid = 1'b1;
        ram.raddr  = ecnt + 1'b1;
        if (result_ready) begin
          if (final_rank) begin
            fill_count_next    = '0;
            overflow_seen_next = 1'b0;
            ecnt_next          = '0;
            state_next         = ST_IDLE;
          end else begin
            ecnt_next  = ecnt + 1'b1;
            state_next = ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      ecnt          <= '0;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      last_hold     <= 1'b0;
    end else begin
      state         <= state_next;
      idx           <= idx_next;
      ecnt          <= ecnt_next;
      fill_count    <= fill_count_next;
      overflow_seen <= overflow_seen_next;
      last_hold     <= last_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
  end

endmodule

### rtl/key_argsort_engine.sv
// Key argsort engine top level: store, sequencer and result register.
`timescale 1ns / 1ps

//  channel  | signals                              | beat
//  ---------+--------------------------------------+------------------------------
//  load     | load_valid, load_ready, load         | one key, last closes the set
//  result   | result_valid, result_ready, result   | one rank of the sorted run
//
// A key goes straight into an empty store; otherwise each held key above it moves
// up one place, walking on the single comparator and the one read port of the
// store. Emission reads each rank into the result register and offers it.
// Reset clears the fill count and the sequencer; the store needs no clearing.
// A stall on result holds the result register and the sequencer.

module key_argsort_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  output logic              load_ready,
  input  kas_pkg::load_t    load,
  output logic              result_valid,
  input  logic              result_ready,
  output kas_pkg::result_t  result
);

  import kas_pkg::*;

  ram_ctl_t ram;
  emit_t    emit;
  entry_t   rdata;

  kas_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load_ready (load_ready),
    .load       (load),
    .result_ready (result_ready),
    .rdata      (rdata),
    .ram        (ram),
    .emit       (emit)
  );

  kas_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  assign result_valid = emit.valid;

  always_ff @(posedge clk) begin
    if (emit.load) begin
      result.sorted_index <= OUT_IDX_W'(rdata.pos);
      result.sorted_key   <= IN_KEY_W'(rdata.key);
      result.run_end      <= emit.run_end;
      result.dropped      <= emit.dropped;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(load_ready && result_valid))
    else $error("load accepted while a result is on offer");

  a_ready_after_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result.run_end |=> load_ready)
    else $error("engine not ready after the final result of a run");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.run_end |=> !load_ready)
    else $error("engine left emission before the final result");

endmodule
